@@ src/slid_pkg.sv @@
package slid_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_HEAD,
    ST_DEL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_INSERTED  = 3'd0,
    RES_DELETED   = 3'd1,
    RES_NOT_FOUND = 3'd2,
    RES_FULL      = 3'd3,
    RES_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_t;

endpackage

@@ src/sorted_list_insert_delete_unit.sv @@
// Sorted multiset of up to CAPACITY signed 8-bit values held in one entry memory with a
// registered read port. A request on in_ (tuser = insert/delete, tdata = value) returns
// one result on out_ (tuser = status, tdata = entry count after the request).
// The memory port is the limit: an insert shifts the entries not smaller than the value up
// by one, reading one entry per cycle from the top; a delete reads every stored entry once,
// moving those behind the match down. An insert into a full store, an insert into an empty
// store and a delete from an empty store go straight from the idle state to the done state.
// Requests are handled one at a time; a new request is taken in the idle state even while
// the last result still waits on out_.
module sorted_list_insert_delete_unit
  import slid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic signed [7:0] in_tdata,   // [7:0] value
  input  logic              in_tuser,   // [0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [4:0] entry_count, [7:5] zero
  output logic [2:0]        out_tuser   // [2:0] status
);

  state_t state_r, state_nxt;

  logic signed [7:0] mem [CAPACITY];
  logic signed [7:0] rdata_r;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic signed [7:0] wd;
  logic [ADDR_W-1:0] ra;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic signed [7:0] v_r, v_nxt;
  status_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [4:0]        out_cnt_r, out_cnt_nxt;

  logic in_acc;
  logic out_free;
  logic is_full;
  logic is_empty;
  logic ins_shift;
  logic del_hit;
  logic del_last;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign is_full    = (cnt_r >= CNT_W'(CAPACITY));
  assign is_empty   = (cnt_r == '0);
  assign ins_shift  = (rdata_r >= v_r);
  assign del_hit    = (rdata_r == v_r);
  assign del_last   = (idx_r == ADDR_W'(cnt_r - 1'b1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r};
  assign out_tuser  = out_status_r;

  // entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_t'(in_tuser) == REQ_INSERT) begin
            state_nxt = (is_full || is_empty) ? ST_DONE : ST_INS;
          end else begin
            state_nxt = is_empty ? ST_DONE : ST_DEL;
          end
        end
      end
      ST_INS: begin
        if (!ins_shift) begin
          state_nxt = ST_DONE;
        end else if (pos_r == ADDR_W'(1)) begin
          state_nxt = ST_INS_HEAD;
        end
      end
      ST_INS_HEAD: state_nxt = ST_DONE;
      ST_DEL: begin
        if (del_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    we             = 1'b0;
    wa             = '0;
    wd             = v_r;
    ra             = '0;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    v_nxt          = v_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          v_nxt = in_tdata;
          if (req_t'(in_tuser) == REQ_INSERT) begin
            if (is_full) begin
              res_nxt = RES_FULL;
            end else if (is_empty) begin
              we      = 1'b1;
              wa      = '0;
              wd      = in_tdata;
              cnt_nxt = cnt_r + 1'b1;
              res_nxt = RES_INSERTED;
            end else begin
              // start at the top entry and shift upward
              ra      = ADDR_W'(cnt_r - 1'b1);
              pos_nxt = ADDR_W'(cnt_r);
            end
          end else begin
            if (is_empty) begin
              res_nxt = RES_EMPTY;
            end else begin
              ra        = '0;
              idx_nxt   = '0;
              found_nxt = 1'b0;
            end
          end
        end
      end
      ST_INS: begin
        we = 1'b1;
        wa = pos_r;
        if (ins_shift) begin
          wd      = rdata_r;
          pos_nxt = pos_r - 1'b1;
          ra      = pos_r - ADDR_W'(2);
        end else begin
          wd      = v_r;
          cnt_nxt = cnt_r + 1'b1;
          res_nxt = RES_INSERTED;
        end
      end
      ST_INS_HEAD: begin
        we      = 1'b1;
        wa      = '0;
        wd      = v_r;
        cnt_nxt = cnt_r + 1'b1;
        res_nxt = RES_INSERTED;
      end
      ST_DEL: begin
        if (found_r) begin
          // close the gap left by the removed entry
          we = 1'b1;
          wa = idx_r - 1'b1;
          wd = rdata_r;
        end else if (del_hit) begin
          found_nxt = 1'b1;
        end
        if (del_last) begin
          if (found_nxt) begin
            cnt_nxt = cnt_r - 1'b1;
            res_nxt = RES_DELETED;
          end else begin
            res_nxt = RES_NOT_FOUND;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          ra      = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_cnt_nxt    = 5'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    v_r          <= v_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((cnt_r == $past(cnt_r) + 1'b1) || (cnt_r == $past(cnt_r) - 1'b1)))
    else $error("entry count moved by more than one");

  a_no_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !we)
    else $error("memory written while result pending");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  a_ins_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_HEAD) |=> (state_r == ST_DONE))
    else $error("head write did not finish the insert");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import slid_pkg::*;

  localparam int NUM_DIRECTED = 23;
  localparam int SEGMENTS     = 10;
  localparam int SEG_ITEMS    = 48;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    status_t    status;
    logic [4:0] count;
  } outcome_t;

  typedef struct packed {
    req_t       kind;
    logic [7:0] value;
    logic       typed;
    status_t    status;
    logic [4:0] count;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic signed [7:0] in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;
  logic [2:0]        out_tuser;

  logic signed [7:0] shadow_list [$];
  outcome_t          expected_outcomes [$];
  outcome_t          head_outcome;
  int                status_seen [5];
  int                requests_sent;
  int                errors;
  int unsigned       cycle_count;
  int                hold_requests;
  int                holds_served;
  int                hold_left;
  int                roll;
  bit                calm;

  // expected results are typed in only where obvious; other rows use the predictor
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{REQ_DELETE, 8'h00, 1'b1, RES_EMPTY,     5'd0},
    '{REQ_INSERT, 8'h7F, 1'b1, RES_INSERTED,  5'd1},
    '{REQ_INSERT, 8'h80, 1'b1, RES_INSERTED,  5'd2},
    '{REQ_INSERT, 8'h00, 1'b1, RES_INSERTED,  5'd3},
    '{REQ_INSERT, 8'h00, 1'b1, RES_INSERTED,  5'd4},
    '{REQ_DELETE, 8'h00, 1'b1, RES_DELETED,   5'd3},
    '{REQ_DELETE, 8'h05, 1'b1, RES_NOT_FOUND, 5'd3},
    '{REQ_INSERT, 8'h10, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'hF0, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'h7F, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'h80, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'h01, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'hFF, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'h40, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'hC0, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'h55, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'hAA, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'h02, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'hFE, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'h00, 1'b0, RES_INSERTED,  5'd0},
    '{REQ_INSERT, 8'h33, 1'b1, RES_FULL,      5'd16},
    '{REQ_DELETE, 8'h80, 1'b1, RES_DELETED,   5'd15},
    '{REQ_DELETE, 8'h44, 1'b1, RES_NOT_FOUND, 5'd15}
  };

  sorted_list_insert_delete_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // updates the sorted shadow list and returns the status of one request
  function automatic void update_sorted_list(input req_t kind, input logic signed [7:0] v,
                                             output status_t st);
    int pos;
    pos = 0;
    if (kind == REQ_INSERT) begin
      if (shadow_list.size() >= CAPACITY) begin
        st = RES_FULL;
      end else begin
        while (pos < shadow_list.size() && v > shadow_list[pos]) pos++;
        shadow_list.insert(pos, v);
        st = RES_INSERTED;
      end
    end else if (shadow_list.size() == 0) begin
      st = RES_EMPTY;
    end else begin
      while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
      if (pos == shadow_list.size()) begin
        st = RES_NOT_FOUND;
      end else begin
        shadow_list.delete(pos);
        st = RES_DELETED;
      end
    end
  endfunction

  function automatic logic [7:0] pick_value(input req_t kind);
    int r;
    r = $urandom_range(0, 9);
    // a narrow band keeps duplicates and hits common
    if (r < 4) return 8'($urandom_range(0, 6)) - 8'd3;
    if (r < 6 && kind == REQ_DELETE && shadow_list.size() != 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (r < 7) begin
      case ($urandom_range(0, 3))
        0:       return 8'h80;
        1:       return 8'h7F;
        2:       return 8'hFF;
        default: return 8'h00;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic send_request(input req_t kind, input logic [7:0] value, input logic typed,
                              input status_t st, input logic [4:0] cnt);
    status_t  predicted;
    outcome_t outcome;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    update_sorted_list(kind, value, predicted);
    outcome.status = typed ? st : predicted;
    outcome.count  = typed ? cnt : 5'(shadow_list.size());
    expected_outcomes.push_back(outcome);
    status_seen[int'(predicted)]++;
    requests_sent++;
  endtask

  task automatic idle_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: status %0d, entry_count %0d", out_tuser, out_tdata);
        errors++;
      end else begin
        head_outcome = expected_outcomes.pop_front();
        if (out_tuser !== head_outcome.status) begin
          $error("status: expected %0d, got %0d", head_outcome.status, out_tuser);
          errors++;
        end
        if (out_tdata !== {3'b000, head_outcome.count}) begin
          $error("entry_count: expected %0d, got %0d", head_outcome.count, out_tdata);
          errors++;
        end
      end
    end
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        hold_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  initial begin
    int   fill_bias;
    req_t kind;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].status, directed_rows[i].count);
      idle_gap();
    end

    // alternate fill-heavy and drain-heavy stretches so full and empty both recur
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      calm = (seg == 2 || seg == 7);
      fill_bias = (seg % 2 == 0) ? 80 : 25;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        kind = ($urandom_range(0, 99) < fill_bias) ? REQ_INSERT : REQ_DELETE;
        send_request(kind, pick_value(kind), 1'b0, RES_INSERTED, 5'd0);
        if (seg == 3 && i == 5) hold_requests++;
        if (seg == 6 && i == 20) begin
          in_tvalid <= 1'b0;
          while (expected_outcomes.size() != 0) @(posedge clk);
        end
        idle_gap();
      end
    end

    in_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests: %0d inserted, %0d deleted, %0d not found, %0d full, %0d empty",
             requests_sent, status_seen[RES_INSERTED], status_seen[RES_DELETED],
             status_seen[RES_NOT_FOUND], status_seen[RES_FULL], status_seen[RES_EMPTY]);
    $display("stalls on both sides, one long result hold-off and one full drain pause");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/slid_pkg.sv
src/sorted_list_insert_delete_unit.sv
sim/tb_top.sv
